// File: hw/rtl/leb_pkg.sv
// shared types and constants for the leb128 varint encoder
package leb_pkg;

    localparam int unsigned LimbW   = 64;
    localparam int unsigned ValW    = 3 * LimbW;
    localparam int unsigned GroupW  = 7;
    localparam int unsigned MaxOut  = 28;
    localparam int unsigned CntW    = $clog2(MaxOut);

    localparam logic [1:0] CMD_U64  = 2'd0;
    localparam logic [1:0] CMD_S64  = 2'd1;
    localparam logic [1:0] CMD_S192 = 2'd2;

    localparam logic [7:0] CONT_BIT = 8'h80;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } leb_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } leb_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last;
    } leb_sts_t;

endpackage

// File: hw/rtl/leb128_varint_encoder.sv
// top level of the leb128 varint encoder
//
// input channel s_*: one request per value; s_tuser selects the mode
// (0 unsigned 64-bit, 1 signed 64-bit, 2 signed 192-bit, 3 dropped),
// s_tdata carries the value as three 64-bit limbs, low limb first.
// output channel m_*: one byte per transfer, least significant group
// first, m_tlast set on the final byte of each value.
// a value is encoded by first loading the shift register and then
// stepping out one byte at a time through the shared 7-bit shifter;
// the first byte is registered on the first step after the load. up to
// 10 bytes for the 64-bit modes, up to 28 for the 192-bit mode. a
// dropped request yields nothing.
// s_tready is high while no value is being encoded; the next request is
// taken while the last byte of the previous one still waits in the
// output register.
// when m_tready is low a full output register holds its byte and the
// shifter pauses. reset (aresetn low, synchronous) empties the output
// register and returns the controller to idle.
module leb128_varint_encoder
    import leb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // value_low, value_mid, value_high
    input  logic [1:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // out_byte
    output logic         m_tlast    // is_last
);

    leb_cmd_t cmd;
    leb_sts_t sts;

    leb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    leb_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: hw/rtl/leb_ctrl.sv
// controller: request intake and byte sequencing state machine
module leb_ctrl
    import leb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,
    input  leb_sts_t   sts,
    output leb_cmd_t   cmd
);

    leb_state_t state_reg, state_next;
    logic       accept;
    logic       known_cmd;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign known_cmd = (s_tuser == CMD_U64) || (s_tuser == CMD_S64) || (s_tuser == CMD_S192);

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && known_cmd) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sts.out_free) begin
                    cmd.step = 1'b1;
                    if (sts.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_step_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> state_reg == ST_RUN)
        else $error("byte step outside run state");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && sts.last) |=> state_reg == ST_IDLE)
        else $error("final byte did not return to idle");
    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_RUN)
        else $error("load did not start a run");
`endif

endmodule

// File: hw/rtl/leb_dp.sv
// datapath: value shifter, byte counter, end detection and output register
module leb_dp
    import leb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  leb_cmd_t              cmd,
    output leb_sts_t              sts,
    input  logic [1:0]            s_tuser,
    input  logic [ValW-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);

    logic [ValW-1:0]   val_reg, val_next;
    logic [ValW-1:0]   load_val;
    logic [ValW-1:0]   shifted;
    logic              signed_reg;
    logic [CntW-1:0]   cnt_reg;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic              m_tlast_reg;
    logic [GroupW-1:0] grp;
    logic              fill;
    logic              rem_zero;
    logic              rem_ones;
    logic              done;
    logic [LimbW-1:0]  lo;

    assign lo = s_tdata[LimbW-1:0];

    always_comb begin
        unique case (s_tuser)
            CMD_U64:  load_val = {{(ValW-LimbW){1'b0}}, lo};
            CMD_S64:  load_val = {{(ValW-LimbW){lo[LimbW-1]}}, lo};
            default:  load_val = s_tdata;
        endcase
    end

    assign grp      = val_reg[GroupW-1:0];
    assign fill     = signed_reg & val_reg[ValW-1];
    assign shifted  = {{GroupW{fill}}, val_reg[ValW-1:GroupW]};
    assign rem_zero = (shifted == '0);
    assign rem_ones = (shifted == '1);

    always_comb begin
        if (signed_reg) begin
            done = (rem_zero && !grp[GroupW-1]) || (rem_ones && grp[GroupW-1])
                || (cnt_reg == CntW'(MaxOut - 1));
        end else begin
            done = rem_zero;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign sts.last     = done;

    always_comb begin
        val_next = val_reg;
        if (cmd.load) begin
            val_next = load_val;
        end else if (cmd.step) begin
            val_next = shifted;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        if (cmd.load) begin
            signed_reg <= (s_tuser != CMD_U64);
        end
        if (cmd.step) begin
            m_tdata_reg <= done ? {1'b0, grp} : (CONT_BIT | {1'b0, grp});
            m_tlast_reg <= done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                cnt_reg <= '0;
            end else if (cmd.step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.step) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> cnt_reg <= CntW'(MaxOut - 1))
        else $error("byte count past limit");
    a_u64_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && !signed_reg) |-> cnt_reg < CntW'(10))
        else $error("unsigned encoding longer than ten bytes");
    a_cont_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7] == !m_tlast))
        else $error("continuation bit disagrees with last flag");
`endif

endmodule
